// ----- rtl/selq_pkg.sv -----
// Package for the shared/exclusive lock queue.
// Holds acknowledgment codes, controller states and the controller/datapath
// command and status structs. No dependencies.
package selq_pkg;

	// Holder count width and its saturation point
	localparam int unsigned HOLDER_BITS = 17;
	localparam logic [HOLDER_BITS-1:0] HOLDER_MAX = 17'h1FFFF;

	// Acknowledgment kinds carried on the result word
	typedef enum logic [1:0] {
		ACK_LOCK    = 2'd0,
		ACK_LOCKALL = 2'd1,
		ACK_UNLOCK  = 2'd2,
		ACK_REJECT  = 2'd3
	} ack_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_CHECK,
		ST_FLUSH,
		ST_UNLK,
		ST_REJ
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic cap_in;     // capture the accepted input word
		logic enqueue;    // write request at tail
		logic release_h;  // drop one holder, saturating at zero
		logic grant;      // take head into the pending slot
		logic push_pend;  // move pending result to the output register
		logic push_last;  // last flag for the pushed pending result
		logic emit_final; // load output with final_kind, last set
		ack_t final_kind;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic is_unlock;
		logic full;
		logic grantable;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/selq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module selq_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/selq_ctrl.sv -----
// Controller state machine for the lock queue.
// Depends on selq_pkg; drives cmd_t to the datapath and reads sts_t back.
module selq_ctrl
	import selq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!sts.is_unlock && sts.full) state_d = ST_REJ;
				else state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.grantable) begin
					if (!sts.pend_valid || sts.out_free) state_d = ST_READ;
				end else if (sts.is_unlock) begin
					state_d = ST_UNLK;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) state_d = ST_IDLE;
			end
			ST_UNLK: begin
				if (!sts.pend_valid && sts.out_free) state_d = ST_IDLE;
			end
			ST_REJ: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		cmd.final_kind = ACK_UNLOCK;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.cap_in = in_valid;
			end
			ST_EXEC: begin
				if (sts.is_unlock) cmd.release_h = 1'b1;
				else if (!sts.full) cmd.enqueue = 1'b1;
			end
			ST_READ: begin
				cmd = '0;
				cmd.final_kind = ACK_UNLOCK;
			end
			ST_CHECK: begin
				if (sts.grantable && (!sts.pend_valid || sts.out_free)) begin
					cmd.grant     = 1'b1;
					cmd.push_pend = sts.pend_valid;
				end
			end
			ST_FLUSH: begin
				if (sts.pend_valid && sts.out_free) begin
					cmd.push_pend = 1'b1;
					cmd.push_last = 1'b1;
				end
			end
			ST_UNLK: begin
				if (sts.out_free) begin
					if (sts.pend_valid) cmd.push_pend = 1'b1;
					else cmd.emit_final = 1'b1;
				end
			end
			ST_REJ: begin
				cmd.final_kind = ACK_REJECT;
				cmd.emit_final = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ----- rtl/selq_dp.sv -----
// Datapath for the lock queue: input capture, request RAM, pointers,
// holder state, pending result slot and output register.
// Depends on selq_pkg and selq_ram.
module selq_dp
	import selq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned RANK_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        operation,
	input  logic [15:0] src_rank,
	input  logic        lock_shared,
	input  logic        lock_all,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  ack_kind,
	output logic [15:0] dest_rank,
	output logic        last,
	input  cmd_t        cmd,
	output sts_t        sts
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned ENT_W = RANK_BITS + 2;

	// Captured input word
	logic                 unlock_q;
	logic [RANK_BITS-1:0] rank_q;
	logic                 shared_q;
	logic                 all_q;

	// Queue and holder state
	logic [PTR_W-1:0]       head_q, tail_q;
	logic [OCC_W-1:0]       occ_q;
	logic [HOLDER_BITS-1:0] cnt_q;
	logic                   hshared_q;

	// Pending result and output register
	logic                 pend_valid_q;
	ack_t                 pend_kind_q;
	logic [RANK_BITS-1:0] pend_rank_q;
	logic                 out_valid_q;
	ack_t                 out_kind_q;
	logic [15:0]          out_rank_q;
	logic                 out_last_q;

	logic [RANK_BITS+15:0] in_ext;
	logic [RANK_BITS+15:0] pend_ext;
	logic [RANK_BITS+15:0] fin_ext;
	logic [ENT_W-1:0]      rdata;
	logic                  out_free;
	logic                  head_shared;

	// Keep the low RANK_BITS bits of the incoming rank
	assign in_ext   = {{RANK_BITS{1'b0}}, src_rank};
	assign pend_ext = {16'b0, pend_rank_q};
	assign fin_ext  = {16'b0, rank_q};

	// Capture the input word
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			unlock_q <= operation;
			rank_q   <= in_ext[RANK_BITS-1:0];
			shared_q <= lock_shared;
			all_q    <= lock_all;
		end
	end

	// Request store, read at head
	selq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.enqueue),
		.waddr(tail_q),
		.wdata({all_q, shared_q, rank_q}),
		.raddr(head_q),
		.rdata(rdata)
	);

	assign head_shared = rdata[RANK_BITS];

	// Advance pointers, occupancy and holder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			occ_q     <= '0;
			cnt_q     <= '0;
			hshared_q <= 1'b0;
		end else begin
			if (cmd.enqueue) begin
				tail_q <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				occ_q  <= occ_q + 1'b1;
			end
			if (cmd.release_h && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.grant) begin
				head_q    <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				occ_q     <= occ_q - 1'b1;
				hshared_q <= head_shared;
				if (cnt_q != HOLDER_MAX) cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Hold the latest grant until the next one or the end of the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.grant) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push_pend) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grant) begin
			pend_kind_q <= rdata[RANK_BITS+1] ? ACK_LOCKALL : ACK_LOCK;
			pend_rank_q <= rdata[RANK_BITS-1:0];
		end
	end

	// Output register: drop on take, load on push
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_pend || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_pend) begin
			out_kind_q <= pend_kind_q;
			out_rank_q <= pend_ext[15:0];
			out_last_q <= cmd.push_last;
		end else if (cmd.emit_final) begin
			out_kind_q <= cmd.final_kind;
			out_rank_q <= fin_ext[15:0];
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign ack_kind  = out_kind_q;
	assign dest_rank = out_rank_q;
	assign last      = out_last_q;

	// Status back to the controller
	assign sts.is_unlock  = unlock_q;
	assign sts.full       = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign sts.grantable  = (occ_q != '0) && ((cnt_q == '0) || (hshared_q && head_shared));
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = out_free;

endmodule

// ----- rtl/shared_exclusive_lock_queue.sv -----
// Lock: EXEC enqueues, READ and CHECK repeat per grant, FLUSH pushes the last grant
// with last set; a full queue is rejected in REJ. Unlock: EXEC releases a holder,
// grants likewise, UNLK pushes the last grant then the ack; output stalls make it wait.
// One item is in work at a time; a finished result may wait in the output
// register while the next word is accepted.
// Reset clears pointers, counts and the controller; the queue RAM is not cleared.
module shared_exclusive_lock_queue
	import selq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned RANK_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [15:0] src_rank,
	input  logic        lock_shared,
	input  logic        lock_all,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  ack_kind,
	output logic [15:0] dest_rank,
	output logic        last
);

	cmd_t cmd;
	sts_t sts;

	// Sequence each word
	selq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Queue, holders and result registers
	selq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.RANK_BITS  (RANK_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.src_rank   (src_rank),
		.lock_shared(lock_shared),
		.lock_all   (lock_all),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ack_kind   (ack_kind),
		.dest_rank  (dest_rank),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// ----- rtl/selq_chk.sv -----
// Port-level checks for the lock queue, bound to the top level.
// Depends on selq_pkg.
module selq_chk
	import selq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  ack_kind,
	input logic [15:0] dest_rank,
	input logic        last
);

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ack_kind)
			&& $stable(dest_rank) && $stable(last))
		else $error("stalled result word changed");

	// One word in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while busy");

	// Reject ends its word
	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_kind == ACK_REJECT |-> last)
		else $error("reject without last");

	// Unlock ack ends its word
	a_unlk_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_kind == ACK_UNLOCK |-> last)
		else $error("unlock ack without last");

endmodule

bind shared_exclusive_lock_queue selq_chk u_selq_chk (.*);
